FILE: rtl/core/cch_pkg.sv
// cch_pkg: shared constants, register codes and the arctangent table
// for the tilt-compensated compass heading block. No dependencies.
package cch_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_DEPTH = 24;
  localparam int DEG180 = 11520;
  localparam int DEG360 = 23040;
  localparam int DEG90  = 5760;
  localparam logic signed [31:0] KQ30 = 32'sd652032874;

  localparam int XY_W = 32;
  localparam int Z_W  = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_Y      = 3'd0,
    REG_GAIN_Z      = 3'd1,
    REG_OFFSET_X    = 3'd2,
    REG_OFFSET_Y    = 3'd3,
    REG_OFFSET_Z    = 3'd4,
    REG_HEADING_OFS = 3'd5
  } cfg_reg_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/cch_mul.sv
// cch_mul: signed 32x32 bit-serial shift-add multiplier, one multiplier
// bit per cycle. Uses cch_pkg.
module cch_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [cch_pkg::XY_W-1:0] a,
  input  logic signed [cch_pkg::XY_W-1:0] b,
  output logic                         done,
  output logic signed [2*cch_pkg::XY_W-1:0] prod
);
  localparam int W = cch_pkg::XY_W;

  logic              busy;
  logic [$clog2(W)-1:0] cnt;
  logic signed [2*W-1:0] acc;
  logic signed [2*W-1:0] ash;
  logic [W-1:0]      bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == $clog2(W)'(W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= (2*W)'(a);
      bsh <= b;
      cnt <= '0;
    end else if (busy) begin
      if (bsh[0]) begin
        // sign bit of b carries negative weight
        if (cnt == $clog2(W)'(W-1)) acc <= acc - ash;
        else acc <= acc + ash;
      end
      ash <= ash <<< 1;
      bsh <= bsh >> 1;
      cnt <= cnt + 1'b1;
    end
  end

  assign prod = acc;

endmodule

FILE: rtl/core/cch_cordic.sv
// cch_cordic: iterative CORDIC, one micro-rotation per cycle, rotation
// or vectoring mode. Uses cch_pkg for widths and the arctangent table.
module cch_cordic #(
  parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             rotate,
  input  logic signed [cch_pkg::XY_W-1:0]  x0,
  input  logic signed [cch_pkg::XY_W-1:0]  y0,
  input  logic signed [cch_pkg::Z_W-1:0]   z0,
  output logic                             done,
  output logic signed [cch_pkg::XY_W-1:0]  xo,
  output logic signed [cch_pkg::XY_W-1:0]  yo,
  output logic signed [cch_pkg::Z_W-1:0]   zo
);
  localparam int CW = $clog2(CORDIC_STEPS);

  logic          busy;
  logic          mode_rot;
  logic [CW-1:0] cnt;
  logic signed [cch_pkg::XY_W-1:0] x, y, xs, ys;
  logic signed [cch_pkg::Z_W-1:0]  z, t;
  logic [4:0]    idx;
  logic          dir;

  always_comb begin
    idx = 5'(cnt);
    xs  = x >>> idx;
    ys  = y >>> idx;
    t   = cch_pkg::Z_W'(cch_pkg::atan_lut(idx));
    dir = mode_rot ? !z[cch_pkg::Z_W-1] : !(!y[cch_pkg::XY_W-1] && y != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(CORDIC_STEPS-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= y0;
      z <= z0;
      mode_rot <= rotate;
      cnt <= '0;
    end else if (busy) begin
      if (dir) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign xo = x;
  assign yo = y;
  assign zo = z;

endmodule

FILE: rtl/core/tilt_compensated_compass_heading.sv
// tilt_compensated_compass_heading: top level, sequencer, registers and
// output stage. Depends on cch_pkg, cch_mul and cch_cordic.
//
// Usage: one input word on s_axis carries raw x, y, z magnetometer words
// and pitch and roll angles (1/64 degree). One output word on m_axis
// carries the wrapped heading, the last in-range heading, and in tuser a
// flag that the heading lies strictly inside +-180 degrees.
// Calibration registers are written on the cfg channel (always ready);
// the user must write them only while idle, unenforced by the block.
// One word at a time: s_axis_tready is high only when no word is in work.
// Each word runs nine products through the shared bit-serial multiplier
// and three passes of the shared CORDIC, the last pass skipped when the
// compensated field is zero.
// The result sits in an output register; a stalled receiver holds it,
// and the next word is accepted meanwhile, its result waiting for the
// register to free.
// Reset (rst, synchronous) restores unity gains, zero offsets, heading
// offset 11200 and clears the filtered heading.
module tilt_compensated_compass_heading #(
  parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_x[15:0], raw_y[31:16], raw_z[47:32], pitch_angle[62:48],
  // roll_angle[77:63], zero [79:78]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // heading[15:0], filtered_heading_out[30:16], zero [31]
  output logic [31:0] m_axis_tdata,
  // heading_valid[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cch_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int W  = cch_pkg::XY_W;
  localparam int ZW = cch_pkg::Z_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CP, S_CR, S_MY, S_MZ, S_SSP, S_CSP, S_OX1, S_OX2, S_OX3,
    S_OY1, S_OY2, S_AT, S_FIN
  } state_t;

  state_t state;
  logic   run;

  logic [15:0] gain_y, gain_z;
  logic signed [20:0] offset_x, offset_y, offset_z;
  logic signed [15:0] heading_ofs;
  logic signed [14:0] filtered_heading;

  logic [15:0] raw_y, raw_z;
  logic signed [14:0] pitch, roll;
  logic signed [21:0] mx;
  logic signed [23:0] my, mz;
  logic signed [W-1:0] sp, cp, sr, cr, ssp, csp, ox, oy;
  logic signed [2*W-1:0] acc;
  logic signed [ZW-1:0] zat;
  logic neg;

  logic mul_start, mul_done;
  logic signed [W-1:0] mul_a, mul_b;
  logic signed [2*W-1:0] prod, sum_p, dif_p;

  logic cor_start, cor_done, cor_rot;
  logic signed [W-1:0] cor_x0, cor_y0, cor_xo, cor_yo;
  logic signed [ZW-1:0] cor_z0, cor_zo;

  logic signed [16:0] ny, nz;
  logic signed [15:0] ang;
  logic ang_neg;
  logic signed [ZW-1:0] at_z0;
  logic signed [W-1:0] at_x0, at_y0;
  logic at_zero;
  logic signed [ZW-1:0] zr;
  logic signed [17:0] h, hw;
  logic hvalid;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_y <= 16'd16384;
      gain_z <= 16'd16384;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      heading_ofs <= 16'sd11200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cch_pkg::REG_GAIN_Y:      gain_y <= cfg_data[15:0];
        cch_pkg::REG_GAIN_Z:      gain_z <= cfg_data[15:0];
        cch_pkg::REG_OFFSET_X:    offset_x <= cfg_data;
        cch_pkg::REG_OFFSET_Y:    offset_y <= cfg_data;
        cch_pkg::REG_OFFSET_Z:    offset_z <= cfg_data;
        cch_pkg::REG_HEADING_OFS: heading_ofs <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ny = -17'(signed'(raw_y));
    nz = -17'(signed'(raw_z));
    sum_p = acc + prod;
    dif_p = acc - prod;

    ang = (state == S_CP) ? 16'(pitch) : 16'(roll);
    if (ang > 16'sd11520) ang = ang - 16'sd23040;
    if (ang < -16'sd11520) ang = ang + 16'sd23040;
    ang_neg = 1'b0;
    if (ang > 16'sd5760) begin
      ang = ang - 16'sd11520;
      ang_neg = 1'b1;
    end else if (ang < -16'sd5760) begin
      ang = ang + 16'sd11520;
      ang_neg = 1'b1;
    end

    at_zero = (ox == '0) && (oy == '0);
    if (ox[W-1]) begin
      at_z0 = oy[W-1] ? -ZW'(cch_pkg::DEG180 * 1024) : ZW'(cch_pkg::DEG180 * 1024);
      at_x0 = -ox;
      at_y0 = -oy;
    end else begin
      at_z0 = '0;
      at_x0 = ox;
      at_y0 = oy;
    end

    cor_rot = (state != S_AT);
    if (state == S_AT) begin
      cor_x0 = at_x0;
      cor_y0 = at_y0;
      cor_z0 = at_z0;
    end else begin
      cor_x0 = cch_pkg::KQ30;
      cor_y0 = '0;
      cor_z0 = ZW'(ang) <<< 10;
    end

    case (state)
      S_MY:    begin mul_a = W'(ny);  mul_b = W'({1'b0, gain_y}); end
      S_MZ:    begin mul_a = W'(nz);  mul_b = W'({1'b0, gain_z}); end
      S_SSP:   begin mul_a = sr;      mul_b = sp; end
      S_CSP:   begin mul_a = cr;      mul_b = sp; end
      S_OX1:   begin mul_a = W'(mx);  mul_b = cp; end
      S_OX2:   begin mul_a = W'(my);  mul_b = ssp; end
      S_OX3:   begin mul_a = W'(mz);  mul_b = csp; end
      S_OY1:   begin mul_a = W'(my);  mul_b = cr; end
      S_OY2:   begin mul_a = W'(mz);  mul_b = sr; end
      default: begin mul_a = '0;      mul_b = '0; end
    endcase

    mul_start = !run && (state == S_MY || state == S_MZ || state == S_SSP ||
                         state == S_CSP || state == S_OX1 || state == S_OX2 ||
                         state == S_OX3 || state == S_OY1 || state == S_OY2);
    cor_start = !run && (state == S_CP || state == S_CR ||
                         (state == S_AT && !at_zero));

    zr = zat + ZW'(512);
    h  = 18'(heading_ofs) - 18'(zr >>> 10);
    hw = h;
    if (hw < -18'sd11520) hw = hw + 18'sd23040;
    if (hw > 18'sd11520) hw = hw - 18'sd23040;
    hvalid = (hw > -18'sd11520) && (hw < 18'sd11520);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      run <= 1'b0;
      m_axis_tvalid <= 1'b0;
      filtered_heading <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) m_axis_tvalid <= 1'b0;
      if (mul_start || cor_start) run <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            raw_y <= s_axis_tdata[31:16];
            raw_z <= s_axis_tdata[47:32];
            pitch <= s_axis_tdata[62:48];
            roll  <= s_axis_tdata[77:63];
            mx    <= (22'(signed'(s_axis_tdata[15:0])) <<< 4) - 22'(offset_x);
            state <= S_CP;
          end
        end
        S_CP, S_CR: begin
          if (cor_start) neg <= ang_neg;
          if (cor_done) begin
            run <= 1'b0;
            if (state == S_CP) begin
              sp <= neg ? -cor_yo : cor_yo;
              cp <= neg ? -cor_xo : cor_xo;
              state <= S_CR;
            end else begin
              sr <= neg ? -cor_yo : cor_yo;
              cr <= neg ? -cor_xo : cor_xo;
              state <= S_MY;
            end
          end
        end
        S_MY: if (mul_done) begin
          run <= 1'b0; my <= signed'(prod[33:10]) - 24'(offset_y); state <= S_MZ;
        end
        S_MZ: if (mul_done) begin
          run <= 1'b0; mz <= signed'(prod[33:10]) - 24'(offset_z); state <= S_SSP;
        end
        S_SSP: if (mul_done) begin
          run <= 1'b0; ssp <= prod[61:30]; state <= S_CSP;
        end
        S_CSP: if (mul_done) begin
          run <= 1'b0; csp <= prod[61:30]; state <= S_OX1;
        end
        S_OX1: if (mul_done) begin
          run <= 1'b0; acc <= prod; state <= S_OX2;
        end
        S_OX2: if (mul_done) begin
          run <= 1'b0; acc <= sum_p; state <= S_OX3;
        end
        S_OX3: if (mul_done) begin
          run <= 1'b0; ox <= dif_p[61:30]; state <= S_OY1;
        end
        S_OY1: if (mul_done) begin
          run <= 1'b0; acc <= prod; state <= S_OY2;
        end
        S_OY2: if (mul_done) begin
          run <= 1'b0; oy <= sum_p[61:30]; state <= S_AT;
        end
        S_AT: begin
          if (!run && at_zero) begin
            zat <= '0;
            state <= S_FIN;
          end else if (cor_done) begin
            run <= 1'b0;
            zat <= cor_zo;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata[15:0] <= hw[15:0];
            m_axis_tdata[31] <= 1'b0;
            m_axis_tuser[0] <= hvalid;
            if (hvalid) begin
              filtered_heading <= hw[14:0];
              m_axis_tdata[30:16] <= hw[14:0];
            end else begin
              m_axis_tdata[30:16] <= filtered_heading;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  cch_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  cch_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .rotate (cor_rot),
    .x0     (cor_x0),
    .y0     (cor_y0),
    .z0     (cor_z0),
    .done   (cor_done),
    .xo     (cor_xo),
    .yo     (cor_yo),
    .zo     (cor_zo)
  );

`ifndef SYNTH
  a_filt_tracks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[30:16] == m_axis_tdata[14:0])
    else $error("filtered heading differs from in-range heading");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[0] ==
      ($signed(m_axis_tdata[15:0]) > -16'sd11520 &&
       $signed(m_axis_tdata[15:0]) < 16'sd11520))
    else $error("heading flag disagrees with heading");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block ready again right after accepting a word");
`endif

endmodule

FILE: tb/tilt_compensated_compass_heading_tb.sv
`timescale 1ns / 1ps
// Testbench for tilt_compensated_compass_heading: directed and random words with
// calibration phases, checked against a built-in fixed-point heading predictor.
// Depends on cch_pkg and the block's RTL.
module tilt_compensated_compass_heading_tb;

  localparam int STEPS = cch_pkg::CORDIC_STEPS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic [15:0] rz;
    logic [15:0] ry;
    logic [15:0] rx;
  } mag_word_t;

  typedef struct {
    logic signed [15:0] hdg;
    logic               ok;
    logic signed [14:0] filt;
  } hdg_word_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [cch_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cch_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tilt_compensated_compass_heading i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  mag_word_t pending_words[$];
  hdg_word_t expected_headings[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;
  bit timed_out = 0;

  // predictor state
  longint gy, gz, ofx, ofy, ofz, hofs, filt_hdg;

  function automatic longint fl_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint atan_val(int i);
    return longint'(cch_pkg::atan_lut(i[4:0]));
  endfunction

  task automatic trig(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit neg;
    x = cch_pkg::KQ30; y = 0; neg = 0;
    if (a > cch_pkg::DEG180) a -= cch_pkg::DEG360;
    if (a < -cch_pkg::DEG180) a += cch_pkg::DEG360;
    if (a > cch_pkg::DEG90) begin
      a -= cch_pkg::DEG180; neg = 1;
    end else if (a < -cch_pkg::DEG90) begin
      a += cch_pkg::DEG180; neg = 1;
    end
    z = a * 1024;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= atan_val(i);
      end else begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += atan_val(i);
      end
      x = nx;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    s = y; c = x;
  endtask

  function automatic longint bearing(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? cch_pkg::DEG180 * 1024 : -cch_pkg::DEG180 * 1024;
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += atan_val(i);
      end else begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= atan_val(i);
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic predict_heading(input mag_word_t w);
    longint x, y, z, sp, cp, sr, cr, mx, my, mz, ox, oy, h;
    hdg_word_t e;
    x = longint'($signed(w.rx));
    y = -longint'($signed(w.ry));
    z = -longint'($signed(w.rz));
    trig(longint'(w.pitch), sp, cp);
    trig(longint'(w.roll), sr, cr);
    mx = x * 16 - ofx;
    my = fl_shr(y * gy, 10) - ofy;
    mz = fl_shr(z * gz, 10) - ofz;
    ox = fl_shr(mx * cp + my * fl_shr(sr * sp, 30) - mz * fl_shr(cr * sp, 30), 30);
    oy = fl_shr(my * cr + mz * sr, 30);
    h = -fl_shr(bearing(oy, ox) + 512, 10) + hofs;
    if (h < -cch_pkg::DEG180) h += cch_pkg::DEG360;
    if (h > cch_pkg::DEG180) h -= cch_pkg::DEG360;
    e.ok = (h > -cch_pkg::DEG180 && h < cch_pkg::DEG180);
    if (e.ok) filt_hdg = h;
    e.hdg = h[15:0];
    e.filt = filt_hdg[14:0];
    expected_headings.push_back(e);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d, want %0d", what, got, want);
  endtask

  // driver
  bit s_taken;
  always @(posedge clk) s_taken <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || s_taken)) begin
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        s_axis_tdata <= {2'b00, pending_words[0]};
        predict_heading(pending_words.pop_front());
        s_axis_tvalid <= 1;
      end else begin
        s_axis_tvalid <= 0;
      end
    end
    m_axis_tready <= !rst && (calm || $urandom_range(99) >= 7);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tilt_compensated_compass_heading_tb: done, errors");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_headings.size() == 0) begin
          report("unexpected word", m_axis_tdata, 0);
        end else begin
          hdg_word_t e;
          e = expected_headings.pop_front();
          if ($signed(m_axis_tdata[15:0]) != e.hdg)
            report("heading", $signed(m_axis_tdata[15:0]), e.hdg);
          if (m_axis_tuser[0] != e.ok)
            report("heading_valid", m_axis_tuser[0], e.ok);
          if ($signed(m_axis_tdata[30:16]) != e.filt)
            report("filtered_heading_out", $signed(m_axis_tdata[30:16]), e.filt);
        end
      end
    end
  end

  task automatic write_reg(input cch_pkg::cfg_reg_t idx, input longint v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v[cch_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cch_pkg::REG_GAIN_Y: gy = v & 16'hffff;
      cch_pkg::REG_GAIN_Z: gz = v & 16'hffff;
      cch_pkg::REG_OFFSET_X: ofx = longint'($signed(v[20:0]));
      cch_pkg::REG_OFFSET_Y: ofy = longint'($signed(v[20:0]));
      cch_pkg::REG_OFFSET_Z: ofz = longint'($signed(v[20:0]));
      cch_pkg::REG_HEADING_OFS: hofs = longint'($signed(v[15:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_headings.size() > 0) begin
      @(posedge clk);
      if (idle_cycles > WATCHDOG) begin
        timed_out = 1;
        return;
      end
    end
    repeat (400) @(posedge clk);
  endtask

  function automatic mag_word_t mk(int x, int y, int z, int p, int r);
    mag_word_t w;
    w.rx = x[15:0]; w.ry = y[15:0]; w.rz = z[15:0];
    w.pitch = p[14:0]; w.roll = r[14:0];
    return w;
  endfunction

  function automatic int rnd_angle();
    int k;
    k = $urandom_range(9);
    if (k == 0) return $urandom_range(32767) - 16384;
    if (k == 1) return ($urandom_range(1)) ? cch_pkg::DEG180 : -cch_pkg::DEG180;
    return $urandom_range(2 * cch_pkg::DEG180) - cch_pkg::DEG180;
  endfunction

  function automatic mag_word_t rnd_word();
    int k;
    k = $urandom_range(9);
    if (k == 0)
      return mk($urandom_range(3) - 1, $urandom_range(3) - 1, $urandom_range(3) - 1,
                rnd_angle(), rnd_angle());
    if (k < 4)
      return mk($urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                $urandom_range(2000) - 1000, rnd_angle(), rnd_angle());
    return mk($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
              rnd_angle(), rnd_angle());
  endfunction

  initial begin
    longint ho;
    gy = 16384; gz = 16384; ofx = 0; ofy = 0; ofz = 0; hofs = 11200; filt_hdg = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: field extremes, zero vector, negative x with zero y, wrap, exact 180
    pending_words.push_back(mk(0, 0, 0, 0, 0));
    pending_words.push_back(mk(-100, 0, 0, 0, 0));
    pending_words.push_back(mk(100, 0, 0, 0, 0));
    pending_words.push_back(mk(32767, 32767, 32767, cch_pkg::DEG180, cch_pkg::DEG180));
    pending_words.push_back(mk(-32768, -32768, -32768, -cch_pkg::DEG180, -cch_pkg::DEG180));
    pending_words.push_back(mk(65535, 0, 65535, 16383, -16384));
    pending_words.push_back(mk(1000, 1000, -1000, cch_pkg::DEG90, -cch_pkg::DEG90));
    pending_words.push_back(mk(-500, 300, 0, 12000, -12000));
    pending_words.push_back(mk(0, 500, 0, 0, 0));
    pending_words.push_back(mk(0, -500, 0, 0, 0));
    pending_words.push_back(mk(21845, 43690, 21845, 10922, -10923));
    drain();

    write_reg(cch_pkg::REG_HEADING_OFS, 0);
    pending_words.push_back(mk(-100, 0, 0, 0, 0));
    pending_words.push_back(mk(100, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8 && !timed_out; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: begin
          write_reg(cch_pkg::REG_GAIN_Y, 0); write_reg(cch_pkg::REG_GAIN_Z, 65535);
          write_reg(cch_pkg::REG_OFFSET_X, -1048576);
          write_reg(cch_pkg::REG_OFFSET_Y, 1048575);
          write_reg(cch_pkg::REG_OFFSET_Z, -1048576);
          write_reg(cch_pkg::REG_HEADING_OFS, -23040);
        end
        1: begin
          write_reg(cch_pkg::REG_GAIN_Y, 65535); write_reg(cch_pkg::REG_GAIN_Z, 0);
          write_reg(cch_pkg::REG_OFFSET_X, 1048575);
          write_reg(cch_pkg::REG_OFFSET_Y, -1048576);
          write_reg(cch_pkg::REG_OFFSET_Z, 1048575);
          write_reg(cch_pkg::REG_HEADING_OFS, 23040);
        end
        2: begin
          write_reg(cch_pkg::REG_GAIN_Y, 16384); write_reg(cch_pkg::REG_GAIN_Z, 16384);
          write_reg(cch_pkg::REG_OFFSET_X, 0); write_reg(cch_pkg::REG_OFFSET_Y, 0);
          write_reg(cch_pkg::REG_OFFSET_Z, 0);
          write_reg(cch_pkg::REG_HEADING_OFS, 11200);
        end
        default: begin
          write_reg(cch_pkg::REG_GAIN_Y, $urandom_range(65535));
          write_reg(cch_pkg::REG_GAIN_Z, $urandom_range(65535));
          write_reg(cch_pkg::REG_OFFSET_X, $urandom_range(2097151));
          write_reg(cch_pkg::REG_OFFSET_Y, $urandom_range(2097151));
          write_reg(cch_pkg::REG_OFFSET_Z, $urandom_range(2097151));
          ho = ($urandom_range(3) == 0) ? 32767 - $urandom_range(65535)
                                         : $urandom_range(2 * cch_pkg::DEG360) - cch_pkg::DEG360;
          write_reg(cch_pkg::REG_HEADING_OFS, ho & 16'hffff);
        end
      endcase
      for (int n = 0; n < 200; n++) pending_words.push_back(rnd_word());
      drain();
    end

    if (timed_out) begin
      $display("tilt_compensated_compass_heading_tb: done, errors");
    end else if (errors == 0 && expected_headings.size() == 0) begin
      $display("tilt_compensated_compass_heading_tb: done, clean");
    end else begin
      $display("tilt_compensated_compass_heading_tb: done, errors");
    end
    $finish;
  end
endmodule
